### src/mlfq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MLFQ scheduler package
// Shared constants, the sequencer state type and the per-level control word.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_LEVELS      = 3;
  localparam int unsigned DEF_PID_WIDTH   = 10;

  // Fixed field widths.
  localparam int unsigned NOW_W = 32;
  localparam int unsigned BP_W  = 16;

  // Boost period after reset.
  localparam logic [BP_W-1:0] BOOST_RESET = 16'd1000;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_JOIN,
    S_BWAIT,
    S_BOOST,
    S_SEL,
    S_PICK
  } state_e;

  // Operations on one level's chain of cells in a cycle.
  typedef struct packed {
    logic rot;   // rotate the chain by one cell
    logic upd;   // while rotating, refresh a matching head word
    logic push;  // append a word at the tail
    logic pop;   // remove the word at a position, closing the gap
  } lvl_ctrl_t;

endpackage
`default_nettype wire

### src/mlfq_three_level_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Three-level MLFQ scheduler
// Keeps one queue per level as a chain of cells, folds each active-list word
// into the queues, boosts on the period and picks the next process.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Word
//  --------+------------------------+----------------------------------------
//  in      | in_valid_i/in_stall_o  | pid, on_io, first, last, running_pid, now
//  out     | out_valid_o/out_stall_i| chosen_pid, chosen_level, dropped
//  cfg     | cfg_valid_i/cfg_ready_o| boost_period
//
//  One word at a time. Each word takes one rotation pass of all level
//  chains in parallel. A last word also waits for the bit-serial
//  remainder unit, which starts when the word is accepted, then, on a zero
//  remainder, drains the lower levels bottom first, makes a second rotation
//  pass and picks. The result sits in an output register; the pick waits
//  only while an earlier result is still stalled. Reset empties all levels.
// ----------------------------------------------------------------------------
module mlfq_three_level_scheduler_top #(
  parameter int unsigned QUEUE_DEPTH = mlfq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned LEVELS      = mlfq_pkg::DEF_LEVELS,
  parameter int unsigned PID_WIDTH   = mlfq_pkg::DEF_PID_WIDTH,
  localparam int unsigned LVL_W      = $clog2(LEVELS + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [PID_WIDTH-1:0]        pid_i,
  input  wire logic                        on_io_i,
  input  wire logic                        first_i,
  input  wire logic                        last_i,
  input  wire logic signed [PID_WIDTH:0]   running_pid_i,
  input  wire logic [mlfq_pkg::NOW_W-1:0]  now_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed [PID_WIDTH:0]        chosen_pid_o,
  output logic [LVL_W-1:0]                 chosen_level_o,
  output logic                             dropped_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [mlfq_pkg::BP_W-1:0]   cfg_data_i
);

  localparam int unsigned IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LIDX_W = $clog2(LEVELS);

  mlfq_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0]           step_q, step_d;
  logic [LIDX_W-1:0]          blvl_q, blvl_d;
  logic                       known_q, known_d;
  logic [PID_WIDTH-1:0]       held_pid_q, held_pid_d;
  logic [LVL_W-1:0]           held_level_q, held_level_d;
  logic                       drop_q, drop_d;
  logic [mlfq_pkg::BP_W-1:0]  bp_q;
  logic                       ov_q, ov_d;

  logic [PID_WIDTH-1:0]       pid_q;
  logic                       io_q, last_q;
  logic                       found_q [LEVELS];
  logic [IDX_W-1:0]           fpos_q  [LEVELS];
  logic [PID_WIDTH-1:0]       fpid_q  [LEVELS];

  logic signed [PID_WIDTH:0]  cpid_q;
  logic [LVL_W-1:0]           clvl_q;
  logic                       cdrop_q;

  mlfq_pkg::lvl_ctrl_t        ctrl      [LEVELS];
  logic [IDX_W-1:0]           pos       [LEVELS];
  logic [PID_WIDTH:0]         push_data [LEVELS];
  logic [PID_WIDTH:0]         head      [LEVELS];
  logic                       hvalid    [LEVELS];
  logic                       match     [LEVELS];
  logic [CNT_W-1:0]           count     [LEVELS];

  logic                       accept, out_free, any_match, any_found, mod_busy, mod_zero;
  logic [LIDX_W-1:0]          dest, sel;
  logic [PID_WIDTH:0]         key;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = state_q != mlfq_pkg::S_IDLE;
  assign out_free    = !ov_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign key         = {io_q, pid_q};

  // Demotion target: one level down, the bottom level is the floor.
  assign dest = (held_level_q < LVL_W'(LEVELS)) ? held_level_q[LIDX_W-1:0]
                                                : LIDX_W'(LEVELS - 1);

  // Level queues.
  for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
    mlfq_level #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PID_WIDTH   (PID_WIDTH)
    ) u_level (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl[g]),
      .step_i       (step_q),
      .pos_i        (pos[g]),
      .key_i        (key),
      .push_data_i  (push_data[g]),
      .head_o       (head[g]),
      .head_valid_o (hvalid[g]),
      .match_o      (match[g]),
      .count_o      (count[g])
    );
  end

  // Boost period remainder.
  mlfq_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && last_i && (bp_q != '0)),
    .dividend_i (now_i),
    .divisor_i  (bp_q),
    .busy_o     (mod_busy),
    .zero_o     (mod_zero)
  );

  // Match and pick reductions across levels.
  always_comb begin
    any_match = 1'b0;
    any_found = 1'b0;
    sel       = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (match[l]) begin
        any_match = 1'b1;
      end
      if (found_q[l]) begin
        any_found = 1'b1;
        sel       = LIDX_W'(l);
      end
    end
  end

  // Sequencer: next state and level controls.
  always_comb begin
    state_d      = state_q;
    step_d       = '0;
    blvl_d       = blvl_q;
    known_d      = known_q;
    held_pid_d   = held_pid_q;
    held_level_d = held_level_q;
    drop_d       = drop_q;
    ov_d         = ov_q && out_stall_i;
    for (int l = 0; l < LEVELS; l++) begin
      ctrl[l]      = '0;
      pos[l]       = '0;
      push_data[l] = key;
    end

    unique case (state_q)
      mlfq_pkg::S_IDLE: begin
        if (accept) begin
          known_d = 1'b0;
          state_d = mlfq_pkg::S_SCAN;
          if (first_i) begin
            drop_d       = 1'b0;
            held_level_d = '0;
            if (!running_pid_i[PID_WIDTH] && (held_level_q != '0)) begin
              if (count[dest] < CNT_W'(QUEUE_DEPTH)) begin
                ctrl[dest].push = 1'b1;
                push_data[dest] = {1'b0, held_pid_q};
              end else begin
                drop_d = 1'b1;
              end
            end
          end
        end
      end

      mlfq_pkg::S_SCAN: begin
        for (int l = 0; l < LEVELS; l++) begin
          ctrl[l].rot = 1'b1;
          ctrl[l].upd = 1'b1;
        end
        if (any_match) begin
          known_d = 1'b1;
        end
        if (step_q == IDX_W'(QUEUE_DEPTH - 1)) begin
          state_d = mlfq_pkg::S_JOIN;
        end else begin
          step_d = step_q + IDX_W'(1);
        end
      end

      mlfq_pkg::S_JOIN: begin
        if (!known_q) begin
          if (count[0] < CNT_W'(QUEUE_DEPTH)) begin
            ctrl[0].push = 1'b1;
          end else begin
            drop_d = 1'b1;
          end
        end
        state_d = last_q ? mlfq_pkg::S_BWAIT : mlfq_pkg::S_IDLE;
      end

      mlfq_pkg::S_BWAIT: begin
        if (bp_q == '0) begin
          state_d = mlfq_pkg::S_SEL;
        end else if (!mod_busy) begin
          blvl_d  = LIDX_W'(LEVELS - 1);
          state_d = mod_zero ? mlfq_pkg::S_BOOST : mlfq_pkg::S_SEL;
        end
      end

      // Drain the lower levels, bottom first, into level one.
      mlfq_pkg::S_BOOST: begin
        if (count[blvl_q] != '0) begin
          ctrl[blvl_q].pop = 1'b1;
          if (count[0] < CNT_W'(QUEUE_DEPTH)) begin
            ctrl[0].push = 1'b1;
            push_data[0] = head[blvl_q];
          end else begin
            drop_d = 1'b1;
          end
        end else if (blvl_q == LIDX_W'(1)) begin
          state_d = mlfq_pkg::S_SEL;
        end else begin
          blvl_d = blvl_q - LIDX_W'(1);
        end
      end

      mlfq_pkg::S_SEL: begin
        for (int l = 0; l < LEVELS; l++) begin
          ctrl[l].rot = 1'b1;
        end
        if (step_q == IDX_W'(QUEUE_DEPTH - 1)) begin
          state_d = mlfq_pkg::S_PICK;
        end else begin
          step_d = step_q + IDX_W'(1);
        end
      end

      mlfq_pkg::S_PICK: begin
        if (out_free) begin
          ov_d    = 1'b1;
          drop_d  = 1'b0;
          state_d = mlfq_pkg::S_IDLE;
          if (any_found) begin
            ctrl[sel].pop = 1'b1;
            pos[sel]      = fpos_q[sel];
            held_pid_d    = fpid_q[sel];
            held_level_d  = LVL_W'(sel) + LVL_W'(1);
          end else begin
            held_level_d = '0;
          end
        end
      end

      default: begin
        state_d = mlfq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mlfq_pkg::S_IDLE;
      step_q       <= '0;
      blvl_q       <= '0;
      known_q      <= 1'b0;
      held_pid_q   <= '0;
      held_level_q <= '0;
      drop_q       <= 1'b0;
      ov_q         <= 1'b0;
      bp_q         <= mlfq_pkg::BOOST_RESET;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      blvl_q       <= blvl_d;
      known_q      <= known_d;
      held_pid_q   <= held_pid_d;
      held_level_q <= held_level_d;
      drop_q       <= drop_d;
      ov_q         <= ov_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bp_q <= cfg_data_i;
      end
    end
  end

  // First ready word of each level during the selection pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LEVELS; l++) begin
        found_q[l] <= 1'b0;
      end
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        if (accept) begin
          found_q[l] <= 1'b0;
        end else if ((state_q == mlfq_pkg::S_SEL) && !found_q[l] && hvalid[l] &&
                     !head[l][PID_WIDTH]) begin
          found_q[l] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LEVELS; l++) begin
      if ((state_q == mlfq_pkg::S_SEL) && !found_q[l] && hvalid[l] &&
          !head[l][PID_WIDTH]) begin
        fpos_q[l] <= step_q;
        fpid_q[l] <= head[l][PID_WIDTH-1:0];
      end
    end
  end

  // Input word capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pid_q   <= pid_i;
      io_q    <= on_io_i;
      last_q  <= last_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if ((state_q == mlfq_pkg::S_PICK) && out_free) begin
      cpid_q  <= any_found ? {1'b0, fpid_q[sel]} : '1;
      clvl_q  <= any_found ? (LVL_W'(sel) + LVL_W'(1)) : '0;
      cdrop_q <= drop_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign chosen_pid_o   = cpid_q;
  assign chosen_level_o = clvl_q;
  assign dropped_o      = cdrop_q;

endmodule
`default_nettype wire

### src/mlfq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MLFQ queue cell
// One slot of a level chain: loads a written word, takes its neighbor's word
// on a shift, or holds.
// ----------------------------------------------------------------------------
module mlfq_cell #(
  parameter int unsigned W = mlfq_pkg::DEF_PID_WIDTH + 1
) (
  input  wire logic         clk_i,
  input  wire logic         wr_en_i,
  input  wire logic         shift_en_i,
  input  wire logic [W-1:0] wdata_i,
  input  wire logic [W-1:0] nbr_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] slot_q;

  // A write has priority over a shift.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slot_q <= wdata_i;
    end else if (shift_en_i) begin
      slot_q <= nbr_i;
    end
  end

  assign q_o = slot_q;

endmodule
`default_nettype wire

### src/mlfq_level.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MLFQ level queue
// A chain of cells with a fill count. Cell 0 is the head; rotation moves each
// word one cell toward the head and wraps the head word to the tail.
// ----------------------------------------------------------------------------
module mlfq_level #(
  parameter int unsigned QUEUE_DEPTH = mlfq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned PID_WIDTH   = mlfq_pkg::DEF_PID_WIDTH,
  localparam int unsigned IDX_W      = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mlfq_pkg::lvl_ctrl_t  ctrl_i,
  input  wire logic [IDX_W-1:0]     step_i,
  input  wire logic [IDX_W-1:0]     pos_i,
  input  wire logic [PID_WIDTH:0]   key_i,
  input  wire logic [PID_WIDTH:0]   push_data_i,
  output logic      [PID_WIDTH:0]   head_o,
  output logic                      head_valid_o,
  output logic                      match_o,
  output logic      [CNT_W-1:0]     count_o
);

  logic [PID_WIDTH:0] cell_q [QUEUE_DEPTH];
  logic [PID_WIDTH:0] wrap;
  logic [CNT_W-1:0]   count_q, count_d;

  // The head cell holds the word at position step_i during a rotation pass.
  assign head_o       = cell_q[0];
  assign head_valid_o = CNT_W'(step_i) < count_q;
  assign match_o      = head_valid_o && (cell_q[0][PID_WIDTH-1:0] == key_i[PID_WIDTH-1:0]);
  assign wrap         = (ctrl_i.upd && match_o) ? key_i : cell_q[0];

  // Chain of cells.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [PID_WIDTH:0] nbr;
    logic               shift_en;
    logic               wr_en;

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nbr = wrap;
    end else begin : g_body
      assign nbr = cell_q[i+1];
    end

    assign shift_en = ctrl_i.rot || (ctrl_i.pop && (IDX_W'(i) >= pos_i));
    assign wr_en    = ctrl_i.push && (count_q == CNT_W'(i));

    mlfq_cell #(
      .W (PID_WIDTH + 1)
    ) u_cell (
      .clk_i      (clk_i),
      .wr_en_i    (wr_en),
      .shift_en_i (shift_en),
      .wdata_i    (push_data_i),
      .nbr_i      (nbr),
      .q_o        (cell_q[i])
    );
  end

  // Fill count.
  always_comb begin
    count_d = count_q;
    if (ctrl_i.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule
`default_nettype wire

### src/mlfq_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MLFQ boost test
// Restoring bit-serial remainder of the time by the boost period, one
// dividend bit a cycle, and a flag for a zero remainder.
// ----------------------------------------------------------------------------
module mlfq_mod (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [mlfq_pkg::NOW_W-1:0]  dividend_i,
  input  wire logic [mlfq_pkg::BP_W-1:0]   divisor_i,
  output logic                             busy_o,
  output logic                             zero_o
);

  localparam int unsigned CW = $clog2(mlfq_pkg::NOW_W + 1);

  logic [CW-1:0]                cnt_q;
  logic [mlfq_pkg::NOW_W-1:0]   num_q;
  logic [mlfq_pkg::BP_W-1:0]    rem_q, rem_d;
  logic [mlfq_pkg::BP_W:0]      rem_ext, diff;

  // One restoring step.
  assign rem_ext = {rem_q, num_q[mlfq_pkg::NOW_W-1]};
  assign diff    = rem_ext - {1'b0, divisor_i};
  assign rem_d   = (rem_ext >= {1'b0, divisor_i}) ? diff[mlfq_pkg::BP_W-1:0]
                                                 : rem_ext[mlfq_pkg::BP_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(mlfq_pkg::NOW_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[mlfq_pkg::NOW_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign busy_o = cnt_q != '0;
  assign zero_o = rem_q == '0;

endmodule
`default_nettype wire

### bench/tb_mlfq_three_level_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the three-level MLFQ scheduler
// Feeds active-list words tick by tick through the input channel and checks
// each pick against a software copy of the queues or a table entry. Starts
// with a short table of directed words, then runs random ticks under several
// boost periods and idle or stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_mlfq_three_level_scheduler_top;

  localparam int QD     = mlfq_pkg::DEF_QUEUE_DEPTH;
  localparam int NLVL   = mlfq_pkg::DEF_LEVELS;
  localparam int PW     = mlfq_pkg::DEF_PID_WIDTH;
  localparam int LIMIT  = 1500000;
  localparam int SETTLE = 200;

  typedef enum int {MODE_FREE, MODE_SEND_IDLE, MODE_RECV_STALL, MODE_BOTH} idle_mode_e;

  typedef struct {
    logic [PW-1:0]      pid;
    logic               on_io;
    logic               first;
    logic               last;
    logic signed [PW:0] running;
    logic [31:0]        now;
  } word_t;

  typedef struct {
    logic [PW:0] pid;
    logic [1:0]  lvl;
    logic        drop;
  } pick_t;

  typedef struct {
    word_t w;
    bit    typed;
    pick_t p;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [PW-1:0] pid = '0;
  logic on_io = 1'b0, first = 1'b0, last = 1'b0;
  logic signed [PW:0] running = '0;
  logic [31:0] now = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [15:0] cfg_data = '0;
  wire in_stall, out_valid, dropped, cfg_ready;
  wire signed [PW:0] chosen_pid;
  wire [1:0] chosen_level;

  idle_mode_e mode = MODE_FREE;
  int errors = 0;
  int cycles = 0;
  pick_t picks_due[$];
  row_t table_rows[$];

  // Software copy of the scheduler state.
  logic [PW:0] sq [NLVL][QD];
  int          sq_cnt [NLVL];
  logic [PW-1:0] s_held_pid;
  int          s_held_lvl;
  bit          s_drop;
  logic [15:0] s_period;

  mlfq_three_level_scheduler_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .pid_i(pid), .on_io_i(on_io), .first_i(first), .last_i(last),
    .running_pid_i(running), .now_i(now),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .chosen_pid_o(chosen_pid), .chosen_level_o(chosen_level), .dropped_o(dropped),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always #4 clk = ~clk;

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("mlfq_three_level_scheduler_top verification failed");
      $finish;
    end
  end

  // Receiver stall pattern.
  always @(posedge clk) begin
    case (mode)
      MODE_RECV_STALL: out_stall <= ($urandom_range(99) < 62);
      MODE_BOTH:       out_stall <= ($urandom_range(99) < 8);
      default:         out_stall <= 1'b0;
    endcase
  end

  task automatic report(string what, int want, int got);
    $display("MISMATCH %s: expected %0d got %0d at cycle %0d", what, want, got, cycles);
    errors++;
  endtask

  // Check every accepted result word against the oldest pending pick.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (picks_due.size() == 0) begin
        report("unexpected result word", 0, 1);
      end else begin
        pick_t e;
        e = picks_due.pop_front();
        if (chosen_pid !== e.pid) report("chosen_pid", $signed(e.pid), chosen_pid);
        if (chosen_level !== e.lvl) report("chosen_level", e.lvl, chosen_level);
        if (dropped !== e.drop) report("dropped", e.drop, dropped);
      end
    end
  end

  function automatic void sq_push(int l, logic [PW:0] e);
    if (sq_cnt[l] >= QD) begin
      s_drop = 1'b1;
    end else begin
      sq[l][sq_cnt[l]] = e;
      sq_cnt[l]++;
    end
  endfunction

  function automatic logic [PW:0] sq_take(int l, int pos);
    logic [PW:0] e;
    e = sq[l][pos];
    for (int i = pos; i < sq_cnt[l] - 1; i++) sq[l][i] = sq[l][i+1];
    sq_cnt[l]--;
    return e;
  endfunction

  // Fold one word into the queues; returns 1 with a pick on a last word.
  function automatic bit sched_step(word_t w, output pick_t p);
    bit known;
    bit found;
    logic [PW:0] t;
    known = 0;
    found = 0;
    p = '{pid: '1, lvl: 2'd0, drop: 1'b0};
    if (w.first) begin
      s_drop = 1'b0;
      if (!w.running[PW] && s_held_lvl != 0)
        sq_push(s_held_lvl < NLVL ? s_held_lvl : NLVL - 1, {1'b0, s_held_pid});
      s_held_lvl = 0;
    end
    for (int l = 0; l < NLVL; l++)
      for (int i = 0; i < sq_cnt[l]; i++)
        if (sq[l][i][PW-1:0] == w.pid) begin
          sq[l][i] = {w.on_io, w.pid};
          known = 1;
        end
    if (!known) sq_push(0, {w.on_io, w.pid});
    if (!w.last) return 0;
    // Priority boost drains the lower levels into the top one, bottom first.
    if (s_period != 0 && (w.now % s_period) == 0)
      for (int l = NLVL - 1; l >= 1; l--)
        while (sq_cnt[l] != 0) sq_push(0, sq_take(l, 0));
    for (int l = 0; l < NLVL && !found; l++)
      for (int i = 0; i < sq_cnt[l]; i++)
        if (!sq[l][i][PW]) begin
          t = sq_take(l, i);
          p.pid = {1'b0, t[PW-1:0]};
          p.lvl = 2'(l + 1);
          found = 1;
          break;
        end
    if (found) begin
      s_held_pid = p.pid[PW-1:0];
      s_held_lvl = p.lvl;
    end else begin
      s_held_lvl = 0;
    end
    p.drop = s_drop;
    s_drop = 1'b0;
    return 1;
  endfunction

  // Present one word, hold it until accepted, then queue its pick if any.
  task automatic send(word_t w, bit typed, pick_t tp);
    int gap;
    pick_t p;
    gap = 0;
    if (mode == MODE_SEND_IDLE) while ($urandom_range(99) < 62) gap++;
    if (mode == MODE_BOTH) while ($urandom_range(99) < 8) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pid <= w.pid; on_io <= w.on_io; first <= w.first; last <= w.last;
    running <= w.running; now <= w.now;
    do @(posedge clk); while (in_stall);
    if (sched_step(w, p)) picks_due.push_back(typed ? tp : p);
  endtask

  task automatic write_period(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    s_period = v;
  endtask

  // Wait until every pick is in, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic void add_row(logic [PW-1:0] p, bit io, bit f, bit l,
                                  int run, logic [31:0] t, bit typed,
                                  int epid, int elvl, bit edrop);
    row_t r;
    r.w = '{pid: p, on_io: io, first: f, last: l, running: (PW+1)'(run), now: t};
    r.typed = typed;
    r.p = '{pid: (PW+1)'(epid), lvl: 2'(elvl), drop: edrop};
    table_rows.push_back(r);
  endfunction

  // One random tick of active-list words.
  task automatic random_tick(int pool, int period, output int sent);
    int len;
    word_t w;
    pick_t none;
    none = '{pid: '0, lvl: '0, drop: 1'b0};
    len = $urandom_range(1, 6);
    if ($urandom_range(99) < 5) len = $urandom_range(17, 22);
    for (int k = 0; k < len; k++) begin
      w.pid = ($urandom_range(99) < 10) ? PW'($urandom) : PW'($urandom_range(pool - 1));
      w.on_io = ($urandom_range(99) < 30);
      w.first = (k == 0);
      w.last = (k == len - 1);
      // A little noise: broken marks.
      if ($urandom_range(99) < 4) begin
        w.first = 1'($urandom);
        w.last = 1'($urandom);
      end
      case ($urandom_range(9))
        0, 1:    w.running = (PW+1)'(-1);
        2:       w.running = (PW+1)'(-int'($urandom_range(1, 1024)));
        3:       w.running = (PW+1)'($urandom_range(1023));
        default: w.running = {1'b0, s_held_pid};
      endcase
      if (period != 0 && $urandom_range(99) < 40) w.now = 32'(period * $urandom_range(65535));
      else w.now = $urandom;
      send(w, 1'b0, none);
    end
    sent = len;
  endtask

  initial begin
    logic [15:0] periods [6];
    int sent, total;
    periods = '{16'd1, 16'd65535, 16'd0, 16'd3, 16'd1000, 16'd7};
    for (int l = 0; l < NLVL; l++) sq_cnt[l] = 0;
    s_held_pid = '0;
    s_held_lvl = 0;
    s_drop = 1'b0;
    s_period = mlfq_pkg::BOOST_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, default boost period of 1000.
    add_row(10'd5, 0, 1, 1, -1, 32'd1, 1, 5, 1, 0);
    add_row(10'd1023, 1, 1, 1, -1, 32'd3, 1, -1, 0, 0);
    add_row(10'd0, 0, 1, 0, 5, 32'd0, 0, 0, 0, 0);
    add_row(10'd1023, 0, 0, 1, -1, 32'd2000, 0, 0, 0, 0);
    add_row(10'd512, 0, 1, 1, 1023, 32'd0, 0, 0, 0, 0);
    add_row(10'd512, 1, 1, 1, -1024, 32'hFFFF_FFFF, 0, 0, 0, 0);
    add_row(10'd1, 0, 1, 1, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
    // One tick long enough to overflow the top level.
    for (int k = 0; k < 18; k++)
      add_row(10'(100 + k), k[0], k == 0, k == 17, 1, 32'd7, 0, 0, 0, 0);
    foreach (table_rows[i]) send(table_rows[i].w, table_rows[i].typed, table_rows[i].p);
    drain();

    // Random phases over boost periods and idle patterns.
    total = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_period(periods[ph]);
      mode = idle_mode_e'(ph % 4);
      for (int n = 0; n < 215; n += sent) begin
        random_tick($urandom_range(4, 40), periods[ph], sent);
        // Hold the sender off until the pipe is empty once.
        if (ph == 1 && n < 100 && n + sent >= 100) begin
          in_valid <= 1'b0;
          while (picks_due.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("mlfq_three_level_scheduler_top verification clean");
    end else begin
      $display("mlfq_three_level_scheduler_top verification failed");
    end
    $finish;
  end

endmodule

### mlfq_three_level_scheduler_top.f
src/mlfq_pkg.sv
src/mlfq_cell.sv
src/mlfq_level.sv
src/mlfq_mod.sv
src/mlfq_three_level_scheduler_top.sv
bench/tb_mlfq_three_level_scheduler_top.sv
